FILE: hw/rtl/srq_pkg.sv
package srq_pkg;

    localparam int TS_W   = 31;
    localparam int RANK_W = 8;
    localparam int KEY_W  = TS_W + RANK_W;
    localparam int TOP_W  = 5;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef logic [KEY_W-1:0] t_key;

    // broadcast to every cell in the row
    typedef struct packed {
        logic  ins_en;   // accepted insert, queue not full
        logic  rm_en;    // accepted remove
        t_key  key;      // {timestamp, rank}
    } t_cmd;

    // rank-match results rippling from cell 0 toward the tail
    typedef struct packed {
        logic rm_hit;    // a remove match at or before this cell
        logic q_hit;     // a query match inside the top window
    } t_chain;

endpackage

FILE: hw/rtl/srq_cell.sv
module srq_cell (
    input  logic            i_clk,
    input  srq_pkg::t_cmd   i_cmd,
    input  logic            i_occupied,
    input  logic            i_in_window,
    input  srq_pkg::t_key   i_left_entry,
    input  logic            i_left_gt,
    input  srq_pkg::t_key   i_right_entry,
    input  srq_pkg::t_chain i_chain,
    output srq_pkg::t_key   o_entry,
    output logic            o_gt,
    output srq_pkg::t_chain o_chain
);
    import srq_pkg::*;

    t_key r_entry;
    t_key n_entry;
    logic rank_match;

    // new key sorts before this entry (empty cells always count as "after")
    assign o_gt       = !i_occupied || (i_cmd.key < r_entry);
    assign rank_match = i_occupied &&
                        (r_entry[RANK_W-1:0] == i_cmd.key[RANK_W-1:0]);

    assign o_chain.rm_hit = i_chain.rm_hit || rank_match;
    assign o_chain.q_hit  = i_chain.q_hit  || (rank_match && i_in_window);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins_en && o_gt) begin
            // left neighbor also moves back: take its entry, else the new key lands here
            n_entry = i_left_gt ? i_left_entry : i_cmd.key;
        end else if (i_cmd.rm_en && o_chain.rm_hit) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

FILE: hw/rtl/sorted_request_queue.sv
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_ready    i_mode, i_entry_timestamp, i_process_rank,
//                                           i_top_count
// result    out        o_valid / i_ready    o_in_top, o_removed, o_overflow, o_occupancy
//
// One request per cycle unless a stalled result holds the flow: every cell compares
// against the broadcast key in parallel, and the insert/remove shift happens in the
// same cycle. The result is registered; it shows in the cycle after acceptance.
// A stalled result blocks the next request (o_ready = result slot free or being taken).
// Reset (i_rst_n low, synchronous) empties the queue and the result slot;
// cell contents are not cleared, the entry count marks what is live.
module sorted_request_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_mode,
    input  logic [srq_pkg::TS_W-1:0]    i_entry_timestamp,
    input  logic [srq_pkg::RANK_W-1:0]  i_process_rank,
    input  logic [srq_pkg::TOP_W-1:0]   i_top_count,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_in_top,
    output logic                        o_removed,
    output logic                        o_overflow,
    output logic [srq_pkg::OCC_W-1:0]   o_occupancy
);
    import srq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_mode              mode;
    logic               accept;
    logic               full;
    t_cmd               cmd;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [63:0]        count_wide;

    logic               r_valid;
    logic               r_in_top;
    logic               r_removed;
    logic               r_overflow;
    logic [OCC_W-1:0]   r_occupancy;

    // per-cell wiring; chain[0] is the empty seed at the head
    t_key               entry   [QUEUE_DEPTH];
    logic               gt      [QUEUE_DEPTH];
    t_chain             chain   [QUEUE_DEPTH+1];

    assign mode    = t_mode'(i_mode);
    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign full    = (r_count == CNT_W'(QUEUE_DEPTH));

    assign cmd.key    = {i_entry_timestamp, i_process_rank};
    assign cmd.ins_en = accept && (mode == MODE_INSERT) && !full;
    assign cmd.rm_en  = accept && (mode == MODE_REMOVE);

    assign chain[0] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic occupied;
        logic in_window;
        t_key left_entry;
        logic left_gt;
        t_key right_entry;

        assign occupied  = (CNT_W'(i) < r_count);
        assign in_window = (32'(i) < 32'(i_top_count));

        if (i == 0) begin : g_head
            // head cell: the new key always enters here when it sorts first
            assign left_entry = cmd.key;
            assign left_gt    = 1'b0;
        end else begin : g_body
            assign left_entry = entry[i-1];
            assign left_gt    = gt[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            // tail slot becomes unused after a remove; its value is don't-care
            assign right_entry = entry[i];
        end else begin : g_mid
            assign right_entry = entry[i+1];
        end

        srq_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_occupied    (occupied),
            .i_in_window   (in_window),
            .i_left_entry  (left_entry),
            .i_left_gt     (left_gt),
            .i_right_entry (right_entry),
            .i_chain       (chain[i]),
            .o_entry       (entry[i]),
            .o_gt          (gt[i]),
            .o_chain       (chain[i+1])
        );
    end

    // occupancy after this request
    always_comb begin
        n_count = r_count;
        if (cmd.ins_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (cmd.rm_en && chain[QUEUE_DEPTH].rm_hit) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign count_wide = 64'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_in_top    <= (mode == MODE_QUERY) && chain[QUEUE_DEPTH].q_hit;
            r_removed   <= (mode == MODE_REMOVE) && chain[QUEUE_DEPTH].rm_hit;
            r_overflow  <= (mode == MODE_INSERT) && full;
            r_occupancy <= count_wide[OCC_W-1:0];
        end
    end

    assign o_valid     = r_valid;
    assign o_in_top    = r_in_top;
    assign o_removed   = r_removed;
    assign o_overflow  = r_overflow;
    assign o_occupancy = r_occupancy;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_overflow) |-> full)
        else $error("overflow reported while queue not full");

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $onehot0({r_in_top, r_removed, r_overflow}))
        else $error("more than one result flag set");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ins_en |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow queue");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.rm_en && chain[QUEUE_DEPTH].rm_hit) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove hit did not shrink queue");

endmodule

FILE: tb/sorted_request_queue_tb.sv
`timescale 1ns / 1ps

module sorted_request_queue_tb;
    import srq_pkg::*;

    localparam int QUEUE_DEPTH     = 16;
    localparam int RANDOM_REQUESTS = 1150;
    localparam int PHASES          = 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 8;
    localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

    // One result as the block reports it
    typedef struct packed {
        logic             in_top;
        logic             removed;
        logic             overflow;
        logic [OCC_W-1:0] occupancy;
    } t_status;

    // One row of the directed table; known rows carry a typed-in status
    typedef struct packed {
        t_mode             mode;
        logic [TS_W-1:0]   ts;
        logic [RANK_W-1:0] rank;
        logic [TOP_W-1:0]  top;
        logic              known;
        t_status           status;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [1:0]          i_mode = MODE_NOP;
    logic [TS_W-1:0]     i_entry_timestamp = '0;
    logic [RANK_W-1:0]   i_process_rank = '0;
    logic [TOP_W-1:0]    i_top_count = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic                o_in_top;
    logic                o_removed;
    logic                o_overflow;
    logic [OCC_W-1:0]    o_occupancy;

    // Shadow copy of the sorted queue, updated at each accepted request
    t_key    held_keys [QUEUE_DEPTH];
    int      held_count = 0;
    t_status pending_status [$];
    t_row    directed_rows [$];

    int error_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;

    sorted_request_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_mode            (i_mode),
        .i_entry_timestamp (i_entry_timestamp),
        .i_process_rank    (i_process_rank),
        .i_top_count       (i_top_count),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_in_top          (o_in_top),
        .o_removed         (o_removed),
        .o_overflow        (o_overflow),
        .o_occupancy       (o_occupancy)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Apply one request to the shadow queue and return the status it yields.
    // Keys pack timestamp above rank, so a plain compare gives the order,
    // ties on timestamp falling to the lower rank.
    function automatic t_status queue_update(t_mode mode, logic [TS_W-1:0] ts,
            logic [RANK_W-1:0] rank, logic [TOP_W-1:0] top);
        t_status st;
        t_key    key;
        int      pos;
        int      hit;
        st  = '0;
        key = {ts, rank};
        hit = -1;
        case (mode)
            MODE_INSERT: begin
                if (held_count >= QUEUE_DEPTH) begin
                    st.overflow = 1'b1;   // full: request dropped
                end else begin
                    // strict compare: an equal key lands after its twins
                    pos = held_count;
                    while (pos > 0 && key < held_keys[pos-1]) begin
                        held_keys[pos] = held_keys[pos-1];
                        pos--;
                    end
                    held_keys[pos] = key;
                    held_count++;
                end
            end
            MODE_REMOVE: begin
                for (pos = 0; pos < held_count && hit < 0; pos++) begin
                    if (held_keys[pos][RANK_W-1:0] == rank) hit = pos;
                end
                if (hit >= 0) begin
                    st.removed = 1'b1;
                    for (pos = hit; pos + 1 < held_count; pos++) begin
                        held_keys[pos] = held_keys[pos+1];
                    end
                    held_count--;
                end
            end
            MODE_QUERY: begin
                // window is min(top, occupancy)
                for (pos = 0; pos < held_count && pos < int'(top); pos++) begin
                    if (held_keys[pos][RANK_W-1:0] == rank) st.in_top = 1'b1;
                end
            end
            default: begin
            end
        endcase
        st.occupancy = OCC_W'(held_count);
        return st;
    endfunction

    task automatic add_row(t_mode mode, logic [TS_W-1:0] ts, logic [RANK_W-1:0] rank,
            logic [TOP_W-1:0] top, logic known, t_status status);
        t_row r;
        r.mode   = mode;
        r.ts     = ts;
        r.rank   = rank;
        r.top    = top;
        r.known  = known;
        r.status = status;
        directed_rows.push_back(r);
    endtask

    // Offer one request, holding it until accepted. Sender gaps come first,
    // so valid only drops when the next request is not ready to go.
    task automatic send_request(t_mode mode, logic [TS_W-1:0] ts, logic [RANK_W-1:0] rank,
            logic [TOP_W-1:0] top, logic known, t_status typed);
        t_status predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_mode            <= mode;
        i_entry_timestamp <= ts;
        i_process_rank    <= rank;
        i_top_count       <= top;
        do @(posedge i_clk); while (!o_ready);
        predicted = queue_update(mode, ts, rank, top);
        pending_status.push_back(known ? typed : predicted);
    endtask

    // Sender holds off until every outstanding result is back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
    endtask

    // Pick a rank that is currently held most of the time so that removes
    // and queries hit; otherwise a small pool, sometimes the full range.
    function automatic logic [RANK_W-1:0] pick_rank();
        if (held_count > 0 && $urandom_range(99) < 60)
            return held_keys[$urandom_range(held_count - 1)][RANK_W-1:0];
        if ($urandom_range(99) < 70)
            return RANK_W'($urandom_range(7));
        return RANK_W'($urandom_range(255));
    endfunction

    task automatic random_request(int insert_pct);
        t_mode             mode;
        logic [TS_W-1:0]   ts;
        logic [RANK_W-1:0] rank;
        logic [TOP_W-1:0]  top;
        int                r;
        r = $urandom_range(99);
        if ($urandom_range(99) < insert_pct) mode = MODE_INSERT;
        else if (r < 45) mode = MODE_REMOVE;
        else if (r < 90) mode = MODE_QUERY;
        else mode = MODE_NOP;
        // narrow timestamps make ties common; full width covers every bit
        r = $urandom_range(99);
        if (r < 50) ts = TS_W'($urandom_range(15));
        else if (r < 80) ts = TS_W'($urandom_range(1000));
        else ts = TS_W'($urandom);
        rank = pick_rank();
        if ($urandom_range(99) < 30) top = TOP_W'($urandom_range(31));
        else top = TOP_W'($urandom_range(QUEUE_DEPTH));
        send_request(mode, ts, rank, top, 1'b0, '0);
    endtask

    task automatic check_field(string name, logic [OCC_W-1:0] expected,
            logic [OCC_W-1:0] actual);
        if (actual !== expected) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, expected, actual);
            error_count++;
        end
    endtask

    // Receiver: random stalls, and result checking against the oldest
    // outstanding expectation
    always @(posedge i_clk) begin
        t_status want;
        i_ready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %b %b %b %0d", $time,
                         o_in_top, o_removed, o_overflow, o_occupancy);
                error_count++;
            end else begin
                want = pending_status.pop_front();
                check_field("in_top", OCC_W'(want.in_top), OCC_W'(o_in_top));
                check_field("removed", OCC_W'(want.removed), OCC_W'(o_removed));
                check_field("overflow", OCC_W'(want.overflow), OCC_W'(o_overflow));
                check_field("occupancy", want.occupancy, o_occupancy);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout", $time);
        $display("sorted_request_queue_tb NOT OK");
        $finish;
    end

    initial begin
        int insert_pct;
        int phase;
        int n;

        // empty queue: every operation reports nothing held
        add_row(MODE_QUERY, '0, '0, 5'd16, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd0});
        add_row(MODE_REMOVE, '0, 8'd5, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd0});
        add_row(MODE_NOP, TS_MAX, 8'hFF, 5'd31, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd0});
        // fill to depth: extremes, tie on timestamp, exact duplicates
        add_row(MODE_INSERT, TS_MAX, 8'hFF, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd1});
        add_row(MODE_INSERT, '0, 8'h00, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd2});
        add_row(MODE_INSERT, 31'd100, 8'd7, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd3});
        add_row(MODE_INSERT, 31'd100, 8'd3, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd4});
        add_row(MODE_INSERT, 31'd100, 8'd7, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd5});
        add_row(MODE_INSERT, 31'd50, 8'd1, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd6});
        add_row(MODE_INSERT, 31'd200, 8'd2, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd7});
        add_row(MODE_INSERT, 31'h5555_5555, 8'hAA, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd8});
        add_row(MODE_INSERT, 31'h2AAA_AAAA, 8'h55, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd9});
        add_row(MODE_INSERT, 31'd100, 8'd7, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd10});
        add_row(MODE_INSERT, 31'd1, 8'd4, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd11});
        add_row(MODE_INSERT, 31'd300, 8'd9, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd12});
        add_row(MODE_INSERT, 31'h4000_0000, 8'h80, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd13});
        add_row(MODE_INSERT, 31'd7, 8'd6, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd14});
        add_row(MODE_INSERT, 31'd100, 8'd8, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd15});
        add_row(MODE_INSERT, 31'd99, 8'd10, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd16});
        // full: dropped, contents kept
        add_row(MODE_INSERT, '0, 8'd0, '0, 1'b1, '{1'b0, 1'b0, 1'b1, 5'd16});
        // rank 255 sits last: just outside a window of 15, inside an oversized one
        add_row(MODE_QUERY, '0, 8'hFF, 5'd15, 1'b0, '0);
        add_row(MODE_QUERY, '0, 8'hFF, 5'd31, 1'b0, '0);
        add_row(MODE_QUERY, '0, 8'h00, 5'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd16});
        add_row(MODE_REMOVE, '0, 8'd7, '0, 1'b0, '0);
        add_row(MODE_REMOVE, '0, 8'd200, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd15});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].mode, directed_rows[k].ts, directed_rows[k].rank,
                         directed_rows[k].top, directed_rows[k].known,
                         directed_rows[k].status);
        end
        drain_results();

        // Random phases: no idling, sender gaps, receiver stalls, both.
        // Insert bias changes every 40 requests so the queue swings
        // between empty and full.
        insert_pct = 50;
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 49;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 49;
                end
                default: begin
                    send_idle_pct = 20;
                    stall_pct     = 20;
                end
            endcase
            for (n = 0; n < RANDOM_REQUESTS / PHASES; n++) begin
                if (n % 40 == 0) begin
                    case ($urandom_range(2))
                        0: insert_pct = 25;
                        1: insert_pct = 50;
                        default: insert_pct = 80;
                    endcase
                end
                random_request(insert_pct);
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("sorted_request_queue_tb OK");
        end else begin
            $display("sorted_request_queue_tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: sorted_request_queue.f
hw/rtl/srq_pkg.sv
hw/rtl/srq_cell.sv
hw/rtl/sorted_request_queue.sv
tb/sorted_request_queue_tb.sv
